>>> rtl/iirt_pkg.sv
// Shared types, constants and microcode table for the transposed DF-II IIR filter.
package iirt_pkg;

  localparam int unsigned NCOEF = 7;
  localparam int unsigned NSTEP = 10;
  localparam int unsigned PC_W  = $clog2(NSTEP);

  typedef logic signed [15:0] sample_t;
  typedef logic signed [17:0] coef_t;
  typedef logic signed [33:0] prod_t;
  typedef logic signed [41:0] acc_t;
  typedef logic signed [39:0] dly_t;
  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [1:0]         tap_t;

  localparam coef_t B0_RESET = 18'sd16384;
  localparam dly_t  DW_MAX   = {1'b0, {39{1'b1}}};
  localparam dly_t  DW_MIN   = {1'b1, {39{1'b0}}};
  localparam acc_t  RND_HALF = 42'sd8192;

  typedef enum logic [2:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_B3,
    REG_A1,
    REG_A2,
    REG_A3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  typedef struct packed {
    logic     mul_en;
    reg_idx_e coef;
    logic     op_y;
    acc_op_e  acc_op;
    tap_t     dly_idx;
    logic     y_en;
    logic     wr_en;
    tap_t     wr_idx;
    logic     jmp;
    tap_t     tap;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   step;
    logic   load_x;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    pc_t  pc;
    logic done;
  } seq_status_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '0;
    case (pc)
      pc_t'(0): begin
        w.mul_en = 1'b1; w.coef = REG_B0;
      end
      pc_t'(1): begin
        w.acc_op = ACC_LOAD; w.dly_idx = 2'd0;
        w.mul_en = 1'b1; w.coef = REG_B1;
      end
      pc_t'(2): begin
        w.y_en = 1'b1;
        w.acc_op = ACC_LOAD; w.dly_idx = 2'd1;
      end
      pc_t'(3): begin
        w.mul_en = 1'b1; w.coef = REG_A1; w.op_y = 1'b1;
      end
      pc_t'(4): begin
        w.acc_op = ACC_SUB;
        w.mul_en = 1'b1; w.coef = REG_B2;
      end
      pc_t'(5): begin
        w.wr_en = 1'b1; w.wr_idx = 2'd0; w.jmp = 1'b1; w.tap = 2'd1;
        w.acc_op = ACC_LOAD; w.dly_idx = 2'd2;
        w.mul_en = 1'b1; w.coef = REG_A2; w.op_y = 1'b1;
      end
      pc_t'(6): begin
        w.acc_op = ACC_SUB;
        w.mul_en = 1'b1; w.coef = REG_B3;
      end
      pc_t'(7): begin
        w.wr_en = 1'b1; w.wr_idx = 2'd1; w.jmp = 1'b1; w.tap = 2'd2;
        w.acc_op = ACC_LOAD; w.dly_idx = 2'd3;
        w.mul_en = 1'b1; w.coef = REG_A3; w.op_y = 1'b1;
      end
      pc_t'(8): begin
        w.acc_op = ACC_SUB;
      end
      pc_t'(9): begin
        w.wr_en = 1'b1; w.wr_idx = 2'd2; w.jmp = 1'b1; w.tap = 2'd3;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/iirt_datapath.sv
// Datapath: coefficient registers, shared multiplier, accumulator and delay words.
module iirt_datapath
  import iirt_pkg::*;
#(
  parameter int unsigned TAPS = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctrl_t   ctrl_i,
  input  sample_t x_i,
  input  logic    cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  coef_t   cfg_data_i,
  output sample_t y_o
);

  localparam int unsigned NDly = TAPS - 1;

  coef_t   coef_q [NCOEF];
  dly_t    w_q    [NDly];
  sample_t x_q, y_q;
  prod_t   prod_q;
  acc_t    acc_q;

  ucode_t  uc;
  coef_t   coef_sel;
  sample_t op_sel;
  prod_t   prod_d;
  dly_t    dly_rd;
  dly_t    dly_sat;
  acc_t    acc_d;
  acc_t    rnd;
  logic [27:0] rnd_sh;
  sample_t y_d;

  assign uc       = ctrl_i.uc;
  assign coef_sel = coef_q[uc.coef];
  assign op_sel   = uc.op_y ? y_q : x_q;
  assign prod_d   = coef_sel * op_sel;

  always_comb begin
    dly_rd = '0;
    for (int i = 0; i < NDly; i++) begin
      if (uc.dly_idx == tap_t'(i)) begin
        dly_rd = w_q[i];
      end
    end
  end

  always_comb begin
    case (uc.acc_op)
      ACC_LOAD: acc_d = acc_t'(prod_q) + acc_t'(dly_rd);
      ACC_SUB:  acc_d = acc_q - acc_t'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (acc_q[41:39] == 3'b000 || acc_q[41:39] == 3'b111) begin
      dly_sat = acc_q[39:0];
    end else if (acc_q[41]) begin
      dly_sat = DW_MIN;
    end else begin
      dly_sat = DW_MAX;
    end
  end

  always_comb begin
    rnd    = acc_q + RND_HALF;
    rnd_sh = rnd[41:14];
    if (rnd_sh[27:15] == '0 || rnd_sh[27:15] == '1) begin
      y_d = rnd_sh[15:0];
    end else if (rnd_sh[27]) begin
      y_d = 16'sh8000;
    end else begin
      y_d = 16'sh7fff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= (i == int'(REG_B0)) ? B0_RESET : '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < 3'(NCOEF))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NDly; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NDly; i++) begin
        if (ctrl_i.step && uc.wr_en && (uc.wr_idx == tap_t'(i))) begin
          w_q[i] <= dly_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= x_i;
    end
    if (ctrl_i.step && uc.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.step && uc.y_en) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

>>> rtl/iirt_seq.sv
// Microcode sequencer: step counter, control word fetch, jumps and output register.
module iirt_seq
  import iirt_pkg::*;
#(
  parameter int unsigned TAPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output sample_t     m_tdata_o,
  input  sample_t     y_i,
  output ctrl_t       ctrl_o,
  output seq_status_t status_o
);

  localparam tap_t LastTap = tap_t'(TAPS - 1);

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  logic       out_valid_q;
  sample_t    out_data_q;
  ucode_t     uc;
  logic       last, out_free, step, done;

  assign uc       = ucode_rom(pc_q);
  assign last     = uc.jmp && (uc.tap == LastTap);
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    step    = 1'b0;
    done    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        if (!last || out_free) begin
          step = 1'b1;
          if (last) begin
            done    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= y_i;
    end
  end

  assign s_tready_o    = (state_q == ST_IDLE);
  assign m_tvalid_o    = out_valid_q;
  assign m_tdata_o     = out_data_q;
  assign ctrl_o.uc     = uc;
  assign ctrl_o.step   = step;
  assign ctrl_o.load_x = s_tvalid_i && s_tready_o;
  assign status_o.busy = (state_q == ST_RUN);
  assign status_o.pc   = pc_q;
  assign status_o.done = done;

endmodule

>>> rtl/iir_filter_transposed_df2.sv
// Top level of the microcoded transposed direct form II IIR filter.
//
//   channel   dir   handshake           payload
//   s_*       in    tvalid/tready       tdata[15:0] sample_in
//   m_*       out   tvalid/tready       tdata[15:0] sample_out
//   cfg_*     in    we (no wait)        idx[2:0], data[17:0]
//
// Each sample is accepted and then runs through the microcode steps up to the jump
// on the last tap; the single shared 18x16 multiplier sets the step count.
// Reset restores the coefficients (b0 = 1.0) and clears all delay words.
// The last step waits while the output register holds an untaken beat; a new
// sample is taken as soon as the previous one has moved to the output register.
module iir_filter_transposed_df2
  import iirt_pkg::*;
#(
  parameter int unsigned TAPS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic signed [15:0]  s_tdata_i,   // [15:0] sample_in
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic signed [15:0]  m_tdata_o,   // [15:0] sample_out
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic signed [17:0]  cfg_data_i
);

  ctrl_t       ctrl;
  seq_status_t st;
  sample_t     y;

  iirt_seq #(
    .TAPS(TAPS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .y_i        (y),
    .ctrl_o     (ctrl),
    .status_o   (st)
  );

  iirt_datapath #(
    .TAPS(TAPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .x_i        (s_tdata_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .y_o        (y)
  );

  a_start_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (st.busy && st.pc == '0))
    else $error("sequencer did not start at step zero");

  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.busy |-> (st.pc < pc_t'(NSTEP)))
    else $error("step counter ran past the program");

  a_done_shows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.done |=> (m_tvalid_o && !st.busy))
    else $error("finished sample not presented");

endmodule

>>> tb/iir_filter_transposed_df2_test.sv
// Self-checking testbench for the transposed direct form II IIR filter.
`timescale 1ns / 100ps

module iir_filter_transposed_df2_test;
  import iirt_pkg::*;

  localparam int unsigned TAPS         = 4;
  localparam int          RESET_CYCLES = 7;
  localparam int          SETTLE_CYC   = 24;
  localparam int          LIMIT_CYCLES = 500000;
  localparam int          RAND_PHASES  = 12;
  localparam int          PHASE_ITEMS  = 75;
  localparam longint      COEF_MAX     = 131071;
  localparam longint      COEF_MIN     = -131072;
  localparam longint      COEF_ONE     = 16384;
  localparam longint      COEF_HALF    = 8192;
  localparam longint      Y_MAX        = 32767;
  localparam longint      Y_MIN        = -32768;
  localparam sample_t     SMP_MAX      = 16'sh7fff;
  localparam sample_t     SMP_MIN      = 16'sh8000;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_n;
  logic                s_tvalid = 1'b0;
  logic                s_tready_o;
  logic signed [15:0]  s_tdata = '0;
  logic                m_tvalid_o;
  logic                m_tready = 1'b0;
  logic signed [15:0]  m_tdata_o;
  logic                cfg_we;
  logic [2:0]          cfg_idx;
  logic signed [17:0]  cfg_data;

  coef_t   ff_coef [0:3];
  coef_t   fb_coef [1:3];
  longint  dly_word [0:2];

  sample_t sample_feed[$];
  sample_t expected_samples[$];
  int      items_queued = 0;
  int      beats_sent = 0;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;

  iir_filter_transposed_df2 #(
    .TAPS(TAPS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint sat_delay(input longint v);
    if (v > longint'(DW_MAX)) return longint'(DW_MAX);
    if (v < longint'(DW_MIN)) return longint'(DW_MIN);
    return v;
  endfunction

  function automatic sample_t filter_predict(input sample_t x);
    longint acc;
    longint y;
    longint nxt;
    int     nd;
    int     k;
    nd = TAPS - 1;
    acc = longint'(ff_coef[0]) * longint'(x) + ((nd > 0) ? dly_word[0] : 64'sd0);
    y = (acc + longint'(RND_HALF)) >>> 14;
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    for (k = 1; k <= nd; k++) begin
      nxt = (k < nd) ? dly_word[k] : 64'sd0;
      dly_word[k-1] = sat_delay(longint'(ff_coef[k]) * longint'(x) + nxt
                                - longint'(fb_coef[k]) * y);
    end
    return sample_t'(y[15:0]);
  endfunction

  // drive input beats from the pending queue
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready_o) begin
        expected_samples = {expected_samples, filter_predict(s_tdata)};
        beats_sent++;
      end
      if (!s_tvalid || s_tready_o) begin
        if (sample_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_feed.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // check output beats in order
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0d", $time, m_tdata_o);
          fail_count++;
        end else if (m_tdata_o !== expected_samples[0]) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, expected_samples[0], m_tdata_o);
          fail_count++;
          void'(expected_samples.pop_front());
        end else begin
          void'(expected_samples.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_coef(input logic [2:0] idx, input longint val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[17:0];
    case (idx)
      REG_B0: ff_coef[0] = coef_t'(val[17:0]);
      REG_B1: ff_coef[1] = coef_t'(val[17:0]);
      REG_B2: ff_coef[2] = coef_t'(val[17:0]);
      REG_B3: ff_coef[3] = coef_t'(val[17:0]);
      REG_A1: fb_coef[1] = coef_t'(val[17:0]);
      REG_A2: fb_coef[2] = coef_t'(val[17:0]);
      REG_A3: fb_coef[3] = coef_t'(val[17:0]);
      default: ;
    endcase
  endtask

  task automatic set_coefs(input longint b0, input longint b1, input longint b2,
                           input longint b3, input longint a1, input longint a2,
                           input longint a3);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_B3, b3);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    write_coef(REG_A3, a3);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic feed(input sample_t x);
    sample_feed = {sample_feed, x};
    items_queued++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (beats_sent != items_queued || expected_samples.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic longint rand_coef(input longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  function automatic longint coef_extreme();
    return $urandom_range(1) ? COEF_MAX : COEF_MIN;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      1, 2: return sample_t'(int'($urandom_range(511)) - 256);
      3: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int kind;
    int ph;
    int n;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    ff_coef[0] = coef_t'(COEF_ONE);
    ff_coef[1] = '0;
    ff_coef[2] = '0;
    ff_coef[3] = '0;
    fb_coef[1] = '0;
    fb_coef[2] = '0;
    fb_coef[3] = '0;
    dly_word[0] = 0;
    dly_word[1] = 0;
    dly_word[2] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;

    src_idle_pct = 7;
    snk_idle_pct = 70;

    // reset coefficients pass samples through
    feed('0);
    feed(16'sd1);
    feed(-16'sd1);
    feed(SMP_MAX);
    feed(SMP_MIN);
    feed(16'sd12345);
    feed(-16'sd12345);
    drain();

    // halves round toward plus infinity; unknown index ignored
    write_coef(REG_UNUSED, COEF_MAX);
    set_coefs(COEF_HALF, 0, 0, 0, 0, 0, 0);
    feed(16'sd1);
    feed(-16'sd1);
    feed(16'sd3);
    feed(-16'sd3);
    feed(SMP_MAX);
    feed(SMP_MIN);
    drain();

    // saturate output and stress delay words
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
    feed(SMP_MAX);
    feed(SMP_MAX);
    feed(SMP_MIN);
    feed(SMP_MIN);
    feed(SMP_MAX);
    drain();
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
    feed(SMP_MIN);
    feed(SMP_MAX);
    feed(SMP_MIN);
    feed(SMP_MAX);
    feed('0);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES / 3) begin
        src_idle_pct = 70;
        snk_idle_pct = 7;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      kind = $urandom_range(3);
      case (kind)
        0: set_coefs(rand_coef(COEF_HALF), rand_coef(COEF_HALF), rand_coef(COEF_HALF),
                     rand_coef(COEF_HALF), rand_coef(4096), rand_coef(4096),
                     rand_coef(4096));
        1: set_coefs(rand_coef(COEF_MAX), rand_coef(COEF_MAX), rand_coef(COEF_MAX),
                     rand_coef(COEF_MAX), 0, 0, 0);
        2: set_coefs(rand_coef(COEF_MAX), rand_coef(COEF_MAX), rand_coef(COEF_MAX),
                     rand_coef(COEF_MAX), rand_coef(COEF_MAX), rand_coef(COEF_MAX),
                     rand_coef(COEF_MAX));
        default: set_coefs(coef_extreme(), coef_extreme(), coef_extreme(), coef_extreme(),
                           coef_extreme(), coef_extreme(), coef_extreme());
      endcase
      for (n = 0; n < PHASE_ITEMS; n++)
        feed(rand_sample());
      drain();
    end

    // back to reset values
    set_coefs(COEF_ONE, 0, 0, 0, 0, 0, 0);
    feed(SMP_MAX);
    feed(SMP_MIN);
    feed(16'sd7);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
